// File: hdl/bsfe_pkg.sv
// Package for the byte-stuffed frame encoder: command record passed from
// the front end through the queue to the back end, byte codes and CRC step.
// No dependencies.
package bsfe_pkg;

	localparam logic [7:0]  SYNC_BYTE  = 8'h31;
	localparam logic [7:0]  STUFF_BYTE = 8'h30;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	// one command per accepted in-frame request
	typedef struct packed {
		logic        start;      // emit sync pair and length
		logic        two_len;    // v1.1: length high byte follows
		logic [15:0] len;
		logic        emit_data;
		logic [7:0]  data;
		logic        emit_crc;   // frame closes after the CRC bytes
		logic [15:0] crc;
	} cmd_t;

	// reflected CRC-CCITT (0x8408), one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] d;
		d = b ^ crc[7:0];
		d = d ^ {d[3:0], 4'b0000};
		return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
	endfunction

endpackage

// File: hdl/byte_stuffed_frame_encoder_top.sv
// Top level of the byte-stuffed frame encoder with CRC-16/CCITT trailer.
// Uses bsfe_pkg, bsfe_front, bsfe_queue and bsfe_back.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one payload request per cycle
//   unless stalled: payload_byte, frame_start, frame_end and frame_length
//   (read on starts). Output channel (out_valid / out_stall) gives the framed,
//   stuffed byte stream, one byte per cycle unless stalled, with run_last on
//   the last byte a request caused, frame_done on the final byte of a frame.
//   cfg_wr_en / cfg_wr_data write the format version (0: v1.0, 1: v1.1); write
//   only while the encoder is idle.
// Path: an accepted request is written into the command queue; its first byte
//   goes into the output register once it is at the queue head and the output is free.
// Throughput: the back end sends one byte per cycle while out_stall is low;
//   a request produces 1 byte for a plain payload byte, 2 if it is stuffed,
//   up to 12 for a single-byte v1.1 frame with all but the sync pair stuffed.
//   Requests outside a frame with no start produce nothing and are not
//   queued. The output byte rate is set by the back end.
// Reset: clears the queue, the output valid, frame state (idle), CRC (0xFFFF)
//   and the format version (v1.0).
// Stall: out_stall holds the output register; the command queue keeps
//   taking requests until it is full, then in_stall rises.
module byte_stuffed_frame_encoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        frame_start,
	input  logic        frame_end,
	input  logic [15:0] frame_length,
	// byte stream
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        frame_done
);

	logic            q_full;
	logic            q_push;
	bsfe_pkg::cmd_t  q_wr_data;
	logic            q_pop;
	logic            q_head_valid;
	bsfe_pkg::cmd_t  q_head;

	// front: frame tracking and CRC, one command per in-frame request
	bsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.frame_length (frame_length),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wr_data)
	);

	// decouples request acceptance from byte emission
	bsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_data    (q_wr_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// back: byte sequencing, stuffing and output register
	bsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

endmodule

// File: hdl/bsfe_front.sv
// Front end of the frame encoder: accepts requests, tracks frame state and
// running CRC, and builds one command per in-frame request. Uses bsfe_pkg.
module bsfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        payload_byte,
	input  logic              frame_start,
	input  logic              frame_end,
	input  logic [15:0]       frame_length,
	input  logic              q_full,
	output logic              q_push,
	output bsfe_pkg::cmd_t    q_data
);

	logic        version_q;
	logic        in_frame_q;
	logic [15:0] crc_q;
	logic        accept;
	logic        empty_frame;
	logic [15:0] base_crc;
	logic [15:0] new_crc;
	logic        closes;

	assign in_stall    = q_full;
	assign accept      = in_valid && !q_full;
	assign empty_frame = frame_start && (frame_length == 16'd0);
	assign base_crc    = frame_start ? bsfe_pkg::CRC_INIT : crc_q;
	assign new_crc     = bsfe_pkg::crc_step(base_crc, payload_byte);
	assign closes      = empty_frame || frame_end;

	always_comb begin
		q_data.start     = frame_start;
		q_data.two_len   = version_q;
		q_data.len       = frame_length;
		q_data.emit_data = !empty_frame;
		q_data.data      = payload_byte;
		q_data.emit_crc  = closes;
		q_data.crc       = empty_frame ? bsfe_pkg::CRC_INIT : new_crc;
	end

	// idle items without a start produce nothing
	assign q_push = accept && (frame_start || in_frame_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q  <= 1'b0;
			in_frame_q <= 1'b0;
			crc_q      <= bsfe_pkg::CRC_INIT;
		end else begin
			if (cfg_wr_en) begin
				version_q <= cfg_wr_data;
			end
			if (q_push) begin
				if (closes) begin
					in_frame_q <= 1'b0;
					crc_q      <= bsfe_pkg::CRC_INIT;
				end else begin
					in_frame_q <= 1'b1;
					crc_q      <= new_crc;
				end
			end
		end
	end

endmodule

// File: hdl/bsfe_queue.sv
// Small command queue between front and back end of the frame encoder.
// Register-based ring with head read out directly. Uses bsfe_pkg.
module bsfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bsfe_pkg::cmd_t    wr_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output bsfe_pkg::cmd_t    head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bsfe_pkg::cmd_t  entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/bsfe_back.sv
// Back end of the frame encoder: walks the head command through its byte
// phases, inserts stuff bytes, and drives the output register. Uses bsfe_pkg.
module bsfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bsfe_pkg::cmd_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              frame_done
);

	localparam logic [2:0] PH_SYNC0  = 3'd0;
	localparam logic [2:0] PH_SYNC1  = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CRC_LO = 3'd5;
	localparam logic [2:0] PH_CRC_HI = 3'd6;

	logic       out_valid_q;
	logic       started_q;
	logic       stuff_q;
	logic [2:0] phase_q;

	logic [6:0] mask;
	logic [6:0] above;
	logic [2:0] first_ph;
	logic [2:0] cur_ph;
	logic [2:0] nxt_ph;
	logic       has_next;
	logic [7:0] ph_byte;
	logic       need_stuff;
	logic       adv;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_last;

	assign mask = {head.emit_crc, head.emit_crc, head.emit_data,
		head.start && head.two_len, head.start, head.start, head.start};

	always_comb begin
		first_ph = PH_SYNC0;
		for (int i = 6; i >= 0; i--) begin
			if (mask[i]) begin
				first_ph = 3'(i);
			end
		end
	end

	assign cur_ph = started_q ? phase_q : first_ph;

	always_comb begin
		nxt_ph   = PH_SYNC0;
		has_next = 1'b0;
		for (int i = 0; i < 7; i++) begin
			above[i] = mask[i] && (3'(i) > cur_ph);
		end
		for (int i = 6; i >= 0; i--) begin
			if (above[i]) begin
				nxt_ph   = 3'(i);
				has_next = 1'b1;
			end
		end
	end

	always_comb begin
		case (cur_ph)
			PH_SYNC0:  ph_byte = bsfe_pkg::SYNC_BYTE;
			PH_SYNC1:  ph_byte = bsfe_pkg::SYNC_BYTE;
			PH_LEN_LO: ph_byte = head.len[7:0];
			PH_LEN_HI: ph_byte = head.len[15:8];
			PH_DATA:   ph_byte = head.data;
			PH_CRC_LO: ph_byte = head.crc[7:0];
			PH_CRC_HI: ph_byte = head.crc[15:8];
			default:   ph_byte = head.data;
		endcase
	end

	// sync pair is never stuffed
	assign need_stuff = (ph_byte == bsfe_pkg::SYNC_BYTE) && (cur_ph >= PH_LEN_LO);

	assign adv  = !out_valid_q || !out_stall;
	assign emit = adv && head_valid;

	always_comb begin
		if (stuff_q) begin
			emit_byte = bsfe_pkg::STUFF_BYTE;
			emit_last = !has_next;
		end else begin
			emit_byte = ph_byte;
			emit_last = !need_stuff && !has_next;
		end
	end

	assign pop = emit && emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			stuff_q     <= 1'b0;
			phase_q     <= PH_SYNC0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (emit_last) begin
					started_q <= 1'b0;
					stuff_q   <= 1'b0;
				end else if (!stuff_q && need_stuff) begin
					started_q <= 1'b1;
					stuff_q   <= 1'b1;
					phase_q   <= cur_ph;
				end else begin
					started_q <= 1'b1;
					stuff_q   <= 1'b0;
					phase_q   <= nxt_ph;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte   <= emit_byte;
			run_last   <= emit_last;
			frame_done <= emit_last && head.emit_crc;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sim/testbench.sv
// Testbench for byte_stuffed_frame_encoder_top: random and directed requests,
// framed byte stream checked against an in-bench encoder model.
// Depends on bsfe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module testbench;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam int SETTLE_CYCLES  = 8;     // front end may still hold an ignored request
	localparam int HOLD_CYCLES    = 100;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake on either side

	// one expected byte of the framed stream
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  payload_byte;
	logic        frame_start;
	logic        frame_end;
	logic [15:0] frame_length;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        frame_done;

	// encoder model state
	logic        version_model;
	logic        in_frame_model;
	logic [15:0] crc_model;
	logic [7:0]  pending_bytes [0:11];
	int          pending_count;
	enc_byte_t   expected_stream [$];

	int   mismatch_count = 0;
	int   requests_sent = 0;
	int   quiet_cycles = 0;
	logic idle_enable;     // random gaps on both sides
	logic hold_request;    // receiver holds off for HOLD_CYCLES
	int   hold_count = 0;
	int   stall_left = 0;

	byte_stuffed_frame_encoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.frame_length (frame_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.frame_done   (frame_done)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Encoder model
	// ---------------------------------------------------------------

	// bitwise reflected CRC-CCITT over one byte
	function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// append a byte; a sync code outside the sync pair gets a stuff byte after it
	function automatic void emit_byte(input logic [7:0] b, input logic stuff);
		pending_bytes[pending_count] = b;
		pending_count++;
		if (stuff && b == bsfe_pkg::SYNC_BYTE) begin
			pending_bytes[pending_count] = bsfe_pkg::STUFF_BYTE;
			pending_count++;
		end
	endfunction

	function automatic void emit_crc_trailer();
		emit_byte(crc_model[7:0], 1'b1);
		emit_byte(crc_model[15:8], 1'b1);
	endfunction

	// bytes that one accepted request adds to the stream
	function automatic void predict_stream(input logic [7:0] b, input logic s, input logic e,
			input logic [15:0] len);
		logic      closes;
		enc_byte_t item;
		closes = 1'b0;
		pending_count = 0;
		if (s) begin
			// a start always opens a fresh frame, dropping any open one
			in_frame_model = 1'b1;
			crc_model = bsfe_pkg::CRC_INIT;
			emit_byte(bsfe_pkg::SYNC_BYTE, 1'b0);
			emit_byte(bsfe_pkg::SYNC_BYTE, 1'b0);
			emit_byte(len[7:0], 1'b1);
			if (version_model)
				emit_byte(len[15:8], 1'b1);
			// the full 16-bit length decides an empty frame, even in v1.0
			if (len == 16'h0000) begin
				emit_crc_trailer();
				closes = 1'b1;
			end
		end else if (!in_frame_model) begin
			return;
		end
		if (!closes) begin
			emit_byte(b, 1'b1);
			crc_model = crc_ccitt_byte(crc_model, b);
			if (e) begin
				emit_crc_trailer();
				closes = 1'b1;
			end
		end
		if (closes) begin
			in_frame_model = 1'b0;
			crc_model = bsfe_pkg::CRC_INIT;
		end
		for (int i = 0; i < pending_count; i++) begin
			item.data = pending_bytes[i];
			item.last = (i == pending_count - 1);
			item.done = closes && (i == pending_count - 1);
			expected_stream.push_back(item);
		end
	endfunction

	// predict on each accepted request, then check each accepted byte
	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && in_valid && !in_stall)
			predict_stream(payload_byte, frame_start, frame_end, frame_length);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stream.size() == 0) begin
				$error("unexpected byte on stream: out_byte %h", out_byte);
				mismatch_count++;
			end else begin
				want = expected_stream.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					mismatch_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %b, got %b", want.last, run_last);
					mismatch_count++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %b, got %b", want.done, frame_done);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: end the run if both channels go quiet for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [7:0] rand_payload();
		// sync code often, to exercise stuffing
		if ($urandom_range(0, 3) == 0)
			return bsfe_pkg::SYNC_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	// receiver stall: long hold-off on request, else random runs
	always @(negedge clk) begin
		if (hold_request) begin
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				hold_request = 1'b0;
				hold_count = 0;
			end
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (idle_enable && $urandom_range(0, 3) == 0)
				stall_left = gap_length();
		end
	end

	// Send one request; called and returns at a falling edge. in_valid stays
	// high into the next call when no gap is drawn.
	task automatic send_req(input logic [7:0] b, input logic s, input logic e,
			input logic [15:0] len);
		int gap;
		gap = (idle_enable && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		payload_byte = b;
		frame_start  = s;
		frame_end    = e;
		frame_length = len;
		in_valid     = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	// Well-formed frame of n requests. Length on non-start requests is junk;
	// the encoder must ignore it. Without close the frame is left open.
	task automatic send_frame(input int n, input logic [15:0] len, input logic close);
		for (int i = 0; i < n; i++)
			send_req(rand_payload(), i == 0, close && (i == n - 1),
				(i == 0) ? len : 16'($urandom_range(0, 16'hFFFF)));
	endtask

	// wait until every expected byte is out and the front end is quiet
	task automatic drain_stream();
		in_valid = 1'b0;
		while (expected_stream.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_version(input logic v);
		drain_stream();
		cfg_wr_en     = 1'b1;
		cfg_wr_data   = v;
		version_model = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Extremes and corner cases, both versions.
	task automatic test_directed_cases();
		int crc_lo_sync;
		int crc_hi_sync;
		logic [15:0] c;
		crc_lo_sync = -1;
		crc_hi_sync = -1;
		// payload bytes whose single-byte CRC has a sync code in the low / high byte
		for (int d = 0; d < 256; d++) begin
			c = crc_ccitt_byte(bsfe_pkg::CRC_INIT, d[7:0]);
			if (crc_lo_sync < 0 && c[7:0] == bsfe_pkg::SYNC_BYTE)
				crc_lo_sync = d;
			if (crc_hi_sync < 0 && c[15:8] == bsfe_pkg::SYNC_BYTE)
				crc_hi_sync = d;
		end
		idle_enable = 1'b0;

		// v1.0 (reset value)
		send_req(bsfe_pkg::SYNC_BYTE, 1'b0, 1'b1, 16'hFFFF);  // no start while idle: dropped
		send_req(8'hAB, 1'b1, 1'b1, 16'h0000);         // empty frame
		send_req(8'h00, 1'b1, 1'b1, 16'h0100);         // low byte 0 but not empty
		send_req(8'hFF, 1'b1, 1'b1, 16'h0001);         // single-request frame
		send_req(bsfe_pkg::SYNC_BYTE, 1'b1, 1'b0, 16'h0031);  // stuffed length and payload
		send_req(8'h00, 1'b0, 1'b0, 16'h0000);
		send_req(8'hFF, 1'b0, 1'b1, 16'hFFFF);
		send_req(8'h12, 1'b1, 1'b0, 16'h0003);         // frame abandoned by next start
		send_req(bsfe_pkg::SYNC_BYTE, 1'b1, 1'b1, 16'h0002);
		send_req(bsfe_pkg::SYNC_BYTE, 1'b1, 1'b1, 16'hFFFF);  // length truncated to one byte
		if (crc_lo_sync >= 0)
			send_req(crc_lo_sync[7:0], 1'b1, 1'b1, 16'h0001);
		if (crc_hi_sync >= 0)
			send_req(crc_hi_sync[7:0], 1'b1, 1'b1, 16'h0001);
		send_req(8'h55, 1'b1, 1'b0, 16'h0001);         // more requests than length
		send_req(8'hAA, 1'b0, 1'b0, 16'h5555);
		send_req(8'h0F, 1'b0, 1'b1, 16'hAAAA);

		// v1.1
		write_version(1'b1);
		send_req(8'hFF, 1'b1, 1'b0, 16'h0000);         // empty frame, end ignored
		send_req(bsfe_pkg::SYNC_BYTE, 1'b1, 1'b1, 16'h3131);  // both length bytes and the payload stuffed
		send_req(8'h00, 1'b1, 1'b1, 16'hFFFF);
		send_req(8'h80, 1'b1, 1'b1, 16'h0100);
		if (crc_lo_sync >= 0)
			send_req(crc_lo_sync[7:0], 1'b1, 1'b1, 16'h0001);
		send_req(8'h7E, 1'b0, 1'b0, 16'h0000);         // idle again: dropped
		drain_stream();
	endtask

	// Receiver holds off while requests keep coming; the queue fills and
	// in_stall has to rise.
	task automatic test_output_holdoff();
		idle_enable = 1'b0;
		hold_request = 1'b1;
		send_frame(16, 16'd16, 1'b1);
		drain_stream();
	endtask

	// Sender stops until the stream has fully drained, then resumes.
	task automatic test_sender_pause();
		idle_enable = 1'b1;
		send_frame(4, 16'd4, 1'b1);
		send_frame(3, 16'd3, 1'b1);
		drain_stream();
		send_frame(5, 16'd5, 1'b1);
		drain_stream();
	endtask

	// Random frames over four phases, alternating versions; one phase has no gaps at all.
	task automatic test_random_versions();
		logic phase_version [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
		int   phase_target;
		int   n;
		int   pick;
		logic [15:0] len;
		for (int ph = 0; ph < 4; ph++) begin
			write_version(phase_version[ph]);
			idle_enable = (ph != 1);
			phase_target = requests_sent + 50;
			while (requests_sent < phase_target) begin
				pick = $urandom_range(0, 99);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
				case ($urandom_range(0, 9))
					6, 7:    len = 16'($urandom_range(0, 16'hFFFF));
					8:       len = {bsfe_pkg::SYNC_BYTE, bsfe_pkg::SYNC_BYTE};
					9:       len = 16'(n + 1);
					default: len = 16'(n);
				endcase
				if (pick < 70) begin
					send_frame(n, len, 1'b1);
				end else if (pick < 78) begin
					// empty frame; payload and end flag are don't-care
					send_req(rand_payload(), 1'b1, 1'($urandom_range(0, 1)), 16'h0000);
				end else if (pick < 88) begin
					// broken frame: no end, the next start abandons it
					send_frame(n, len, 1'b0);
				end else begin
					// noise: every field random
					send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)));
				end
			end
		end
		drain_stream();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = 1'b0;
		in_valid       = 1'b0;
		payload_byte   = 8'h00;
		frame_start    = 1'b0;
		frame_end      = 1'b0;
		frame_length   = 16'h0000;
		out_stall      = 1'b0;
		idle_enable    = 1'b0;
		hold_request   = 1'b0;
		version_model  = 1'b0;
		in_frame_model = 1'b0;
		crc_model      = bsfe_pkg::CRC_INIT;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_output_holdoff();
		test_sender_pause();
		test_random_versions();

		if (expected_stream.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_stream.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
